FILE: rtl/aamm_pkg.sv
// ----------------------------------------------------------------------------
// aamm_pkg
// Shared types, constants and small tables for the axis-angle model matrix
// builder.
// ----------------------------------------------------------------------------
package aamm_pkg;

	typedef logic signed [31:0] word_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

	localparam int DIFF_W = 33;
	localparam int ANG_W  = 34;
	localparam int MUL_W  = 35;
	localparam int MAG_W  = MUL_W - 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int Q30    = 30;
	localparam int DIVN_W = 64;
	localparam int DIVD_W = 33;
	localparam int QDEPTH = 2;

	localparam logic [63:0] DEG2RAD_FULL = (64'd31415926 << 32) / 64'd1800000000;
	localparam logic [26:0] DEG2RAD_Q32  = DEG2RAD_FULL[26:0];

	typedef struct packed {
		logic [2:0][DIFF_W-1:0] md;
		logic [2:0]             neg;
		logic [DIFF_W-1:0]      m;
		logic                   err;
		logic [31:0]            ang_mag;
		logic                   ang_neg;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIVN_W-1:0] dividend;
		logic [DIVD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVN_W-1:0] quot;
	} div_rsp_t;

	// Taylor term divisors: sin uses (2n)(2n+1), cos uses (2n-1)(2n)
	function automatic logic [8:0] series_div(logic [3:0] n, logic is_cos);
		logic [8:0] v;
		v = 9'd1;
		if (is_cos) begin
			unique case (n)
				4'd1: v = 9'd2;
				4'd2: v = 9'd12;
				4'd3: v = 9'd30;
				4'd4: v = 9'd56;
				4'd5: v = 9'd90;
				4'd6: v = 9'd132;
				4'd7: v = 9'd182;
				4'd8: v = 9'd240;
				default: v = 9'd1;
			endcase
		end else begin
			unique case (n)
				4'd1: v = 9'd6;
				4'd2: v = 9'd20;
				4'd3: v = 9'd42;
				4'd4: v = 9'd72;
				4'd5: v = 9'd110;
				4'd6: v = 9'd156;
				4'd7: v = 9'd210;
				4'd8: v = 9'd272;
				default: v = 9'd1;
			endcase
		end
		return v;
	endfunction

	// highest shift k of the full turn needed to reduce a 32-bit magnitude
	function automatic int ang_steps(int fb);
		longint unsigned f;
		int k;
		f = 64'd360 << fb;
		k = 0;
		while ((f << (k + 1)) <= 64'h8000_0000) k++;
		return k;
	endfunction

endpackage

FILE: rtl/aamm_front.sv
// ----------------------------------------------------------------------------
// aamm_front
// Input side: takes an item, forms the axis difference, its magnitudes,
// signs and largest component, flags a zero axis, splits the angle sign.
// ----------------------------------------------------------------------------
module aamm_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  aamm_pkg::word_t    angle_deg,
	input  aamm_pkg::word_t    axis_start_x,
	input  aamm_pkg::word_t    axis_start_y,
	input  aamm_pkg::word_t    axis_start_z,
	input  aamm_pkg::word_t    axis_end_x,
	input  aamm_pkg::word_t    axis_end_y,
	input  aamm_pkg::word_t    axis_end_z,
	input  logic               q_full,
	output logic               push,
	output aamm_pkg::item_t    item
);
	import aamm_pkg::*;

	logic signed [DIFF_W-1:0] d [3];
	logic [DIFF_W-1:0]        mag [3];
	logic [DIFF_W-1:0]        m01;

	always_comb begin
		d[0] = DIFF_W'(axis_end_x) - DIFF_W'(axis_start_x);
		d[1] = DIFF_W'(axis_end_y) - DIFF_W'(axis_start_y);
		d[2] = DIFF_W'(axis_end_z) - DIFF_W'(axis_start_z);
		for (int i = 0; i < 3; i++) begin
			mag[i] = d[i][DIFF_W-1] ? DIFF_W'(-d[i]) : DIFF_W'(d[i]);
			item.md[i]  = mag[i];
			item.neg[i] = d[i][DIFF_W-1];
		end
		m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
		item.m       = (m01 > mag[2]) ? m01 : mag[2];
		item.err     = (item.m == '0);
		item.ang_neg = angle_deg[31];
		item.ang_mag = angle_deg[31] ? 32'(-angle_deg) : 32'(angle_deg);
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

FILE: rtl/aamm_queue.sv
// ----------------------------------------------------------------------------
// aamm_queue
// Two-entry queue between the input side and the matrix sequencer.
// ----------------------------------------------------------------------------
module aamm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aamm_pkg::item_t   item_in,
	input  logic              pop,
	output aamm_pkg::item_t   item_out,
	output logic              full,
	output logic              empty
);
	import aamm_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	item_t          mem_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full     = (count_q == (PW+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign item_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= item_in;
	end

endmodule

FILE: rtl/aamm_div.sv
// ----------------------------------------------------------------------------
// aamm_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module aamm_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aamm_pkg::div_req_t   req,
	output aamm_pkg::div_rsp_t   rsp
);
	import aamm_pkg::*;

	localparam int STEPS = DIVN_W / 2;
	localparam int CW    = $clog2(STEPS);

	logic [DIVD_W:0]   rem_q;
	logic [DIVN_W-1:0] quot_q;
	logic [DIVD_W-1:0] dsr_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W:0]   rem_n;
	logic [DIVN_W-1:0] quot_n;

	always_comb begin
		rem_n  = rem_q;
		quot_n = quot_q;
		for (int s = 0; s < 2; s++) begin
			rem_n  = {rem_n[DIVD_W-1:0], quot_n[DIVN_W-1]};
			quot_n = {quot_n[DIVN_W-2:0], 1'b0};
			if (rem_n >= {1'b0, dsr_q}) begin
				rem_n     = rem_n - {1'b0, dsr_q};
				quot_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			quot_q <= quot_n;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: rtl/aamm_back.sv
// ----------------------------------------------------------------------------
// aamm_back
// Matrix sequencer: angle reduction, sin/cos series, axis normalization,
// Rodrigues entries through one shared multiplier and divider, row output.
// ----------------------------------------------------------------------------
module aamm_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  aamm_pkg::item_t         q_item,
	output logic                    pop,
	input  aamm_pkg::word_t [2:0]   trans,
	input  aamm_pkg::word_t [2:0]   scale,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              row_index,
	output aamm_pkg::word_t         entry_c0,
	output aamm_pkg::word_t         entry_c1,
	output aamm_pkg::word_t         entry_c2,
	output aamm_pkg::word_t         entry_c3,
	output logic                    axis_error,
	output logic                    last_row
);
	import aamm_pkg::*;

	localparam int KMAX = ang_steps(FRAC_BITS);
	localparam logic [63:0] FULL64 = 64'd360 << FRAC_BITS;
	localparam logic [63:0] QTR64  = 64'd90 << FRAC_BITS;
	localparam logic [63:0] FSH64  = FULL64 << KMAX;
	localparam logic [ANG_W-1:0] FULL_A  = FULL64[ANG_W-1:0];
	localparam logic [ANG_W-1:0] QTR_A   = QTR64[ANG_W-1:0];
	localparam logic [ANG_W-1:0] FSH_A   = FSH64[ANG_W-1:0];
	localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
	localparam word_t ONE_W  = ONE64[31:0];
	localparam logic signed [MUL_W-1:0] ONE_Q = MUL_W'(64'd1 << Q30);
	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ANG, ST_FIX, ST_QUAD, ST_RAD, ST_XS, ST_XI, ST_X2,
		ST_TSM, ST_TSD, ST_TSW, ST_TCM, ST_TCD, ST_TCW, ST_SC, ST_NORM,
		ST_SQ, ST_SQRT, ST_UDS, ST_UDW, ST_M0, ST_M1, ST_M2, ST_M3,
		ST_M4, ST_M5, ST_EMIT
	} state_t;

	state_t state_q;
	logic [3:0] n_q;
	logic [1:0] idx_q, i_q, j_q, row_q;
	logic       out_valid_q;

	logic [ANG_W-1:0]        r_q, fsh_q;
	logic                    ang_neg_q;
	logic [1:0]              quad_q;
	logic [31:0]             x_q;
	logic [32:0]             x2_q;
	logic [33:0]             ts_q, tc_q;
	logic signed [33:0]      ss_q, cs_q, s_q, c_q;
	logic [DIFF_W-1:0]       md_q [3];
	logic [DIFF_W-1:0]       m_q;
	logic [2:0]              neg_q;
	logic                    err_q;
	logic [63:0]             sum_q, sqn_q, res_q, sqb_q;
	word_t                   u_q [3];
	word_t                   uu_q;
	logic signed [39:0]      acc_q, rv_q;
	word_t                   ent_q [3][3];

	logic [PROD_W-1:0]       p_q;
	logic                    pneg_q;
	logic signed [MUL_W-1:0] ma, mb;
	logic [MAG_W-1:0]        ma_mag, mb_mag;
	logic [37:0]             psh;
	logic signed [38:0]      mulres;
	logic signed [MUL_W-1:0] omc;
	word_t                   kv;

	logic [1:0]   row_index_q;
	word_t        c0_q, c1_q, c2_q, c3_q;
	logic         err_out_q, last_row_q;
	logic         out_load;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [63:0] sq_t;
	logic [63:0] sq_n, sq_r;
	logic        sq_ge;

	aamm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	function automatic word_t sat32(logic signed [38:0] v);
		word_t o;
		if (v > 39'sd2147483647)       o = 32'sh7FFF_FFFF;
		else if (v < -39'sd2147483648) o = 32'sh8000_0000;
		else                           o = 32'(v);
		return o;
	endfunction

	function automatic word_t kval(logic [1:0] i, logic [1:0] j,
		word_t u0, word_t u1, word_t u2);
		word_t o;
		unique case ({i, j})
			4'b0001: o = -u2;
			4'b0010: o = u1;
			4'b0100: o = u2;
			4'b0110: o = -u0;
			4'b1000: o = -u1;
			4'b1001: o = u0;
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic word_t neg_sat(word_t t);
		return (t == 32'sh8000_0000) ? 32'sh7FFF_FFFF : word_t'(-t);
	endfunction

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign omc      = ONE_Q - MUL_W'(c_q);
	assign kv       = kval(i_q, j_q, u_q[0], u_q[1], u_q[2]);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_RAD: begin
				ma = $signed(MUL_W'(r_q));
				mb = $signed(MUL_W'(DEG2RAD_Q32));
			end
			ST_XI: begin
				ma = $signed(MUL_W'(x_q));
				mb = $signed(MUL_W'(x_q));
			end
			ST_TSM: begin
				ma = $signed(MUL_W'(ts_q));
				mb = $signed(MUL_W'(x2_q));
			end
			ST_TCM: begin
				ma = $signed(MUL_W'(tc_q));
				mb = $signed(MUL_W'(x2_q));
			end
			ST_SQ: begin
				if (idx_q != ROW_LAST) begin
					ma = $signed(MUL_W'(md_q[idx_q]));
					mb = $signed(MUL_W'(md_q[idx_q]));
				end
			end
			ST_M0: begin
				ma = MUL_W'(u_q[i_q]);
				mb = MUL_W'(u_q[j_q]);
			end
			ST_M1: begin
				ma = MUL_W'(s_q);
				mb = MUL_W'(kv);
			end
			ST_M2: begin
				ma = omc;
				mb = MUL_W'(uu_q);
			end
			ST_M4: begin
				ma = MUL_W'(rv_q);
				mb = MUL_W'(scale[j_q]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		ma_mag = ma[MUL_W-1] ? MAG_W'(-ma) : MAG_W'(ma);
		mb_mag = mb[MUL_W-1] ? MAG_W'(-mb) : MAG_W'(mb);
	end

	always_ff @(posedge clk) begin
		p_q    <= ma_mag * mb_mag;
		pneg_q <= ma[MUL_W-1] ^ mb[MUL_W-1];
	end

	assign psh    = p_q[PROD_W-1:Q30];
	assign mulres = pneg_q ? -$signed({1'b0, psh}) : $signed({1'b0, psh});

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '1;
		unique case (state_q)
			ST_TSD, ST_TCD: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVN_W'(psh);
				div_req.divisor  = DIVD_W'(series_div(n_q, state_q == ST_TCD));
			end
			ST_UDS: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVN_W'(md_q[i_q]) << Q30;
				div_req.divisor  = DIVD_W'(res_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// integer square root step
	always_comb begin
		sq_t  = res_q + sqb_q;
		sq_ge = (sqn_q >= sq_t);
		sq_n  = sq_ge ? (sqn_q - sq_t) : sqn_q;
		sq_r  = sq_ge ? ((res_q >> 1) + sqb_q) : (res_q >> 1);
	end

	// control and registered output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			idx_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					if (!q_empty) state_q <= q_item.err ? ST_EMIT : ST_ANG;
				end
				ST_ANG:  if (fsh_q == FULL_A) state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_QUAD;
				ST_QUAD: state_q <= ST_RAD;
				ST_RAD:  state_q <= ST_XS;
				ST_XS:   state_q <= ST_XI;
				ST_XI:   state_q <= ST_X2;
				ST_X2: begin
					n_q     <= 4'd1;
					state_q <= ST_TSM;
				end
				ST_TSM:  state_q <= ST_TSD;
				ST_TSD:  state_q <= ST_TSW;
				ST_TSW:  if (div_rsp.done) state_q <= ST_TCM;
				ST_TCM:  state_q <= ST_TCD;
				ST_TCD:  state_q <= ST_TCW;
				ST_TCW: begin
					if (div_rsp.done) begin
						n_q     <= n_q + 1'b1;
						state_q <= (n_q == 4'd8) ? ST_SC : ST_TSM;
					end
				end
				ST_SC:   state_q <= ST_NORM;
				ST_NORM: begin
					idx_q <= '0;
					if (!(m_q[32] || m_q[31]) && (m_q[32:30] != '0))
						state_q <= ST_SQ;
				end
				ST_SQ: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == ROW_LAST) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					i_q <= '0;
					if (sqb_q[0]) state_q <= ST_UDS;
				end
				ST_UDS:  state_q <= ST_UDW;
				ST_UDW: begin
					if (div_rsp.done) begin
						if (i_q == 2'd2) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_M0;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_UDS;
						end
					end
				end
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5: begin
					if (j_q == 2'd2) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= (i_q == 2'd2) ? ST_EMIT : ST_M0;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_M0;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						row_q <= row_q + 1'b1;
						if (row_q == ROW_LAST) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					for (int k = 0; k < 3; k++) md_q[k] <= q_item.md[k];
					neg_q     <= q_item.neg;
					m_q       <= q_item.m;
					err_q     <= q_item.err;
					r_q       <= ANG_W'(q_item.ang_mag);
					ang_neg_q <= q_item.ang_neg;
					fsh_q     <= FSH_A;
					for (int a = 0; a < 3; a++)
						for (int b = 0; b < 3; b++)
							ent_q[a][b] <= (a == b) ? scale[b] : '0;
				end
			end
			ST_ANG: begin
				if (r_q >= fsh_q) r_q <= r_q - fsh_q;
				fsh_q <= fsh_q >> 1;
			end
			ST_FIX: begin
				if (ang_neg_q && (r_q != '0)) r_q <= FULL_A - r_q;
			end
			ST_QUAD: begin
				if (r_q >= 3 * QTR_A) begin
					quad_q <= 2'd3;
					r_q    <= r_q - 3 * QTR_A;
				end else if (r_q >= 2 * QTR_A) begin
					quad_q <= 2'd2;
					r_q    <= r_q - 2 * QTR_A;
				end else if (r_q >= QTR_A) begin
					quad_q <= 2'd1;
					r_q    <= r_q - QTR_A;
				end else begin
					quad_q <= 2'd0;
				end
			end
			ST_XS: x_q <= 32'(p_q >> (FRAC_BITS + 2));
			ST_X2: begin
				x2_q <= 33'(psh);
				ts_q <= 34'(x_q);
				tc_q <= 34'(64'd1 << Q30);
				ss_q <= $signed(34'(x_q));
				cs_q <= $signed(34'(64'd1 << Q30));
			end
			ST_TSW: begin
				if (div_rsp.done) begin
					ts_q <= div_rsp.quot[33:0];
					ss_q <= n_q[0] ? ss_q - $signed(div_rsp.quot[33:0])
						: ss_q + $signed(div_rsp.quot[33:0]);
				end
			end
			ST_TCW: begin
				if (div_rsp.done) begin
					tc_q <= div_rsp.quot[33:0];
					cs_q <= n_q[0] ? cs_q - $signed(div_rsp.quot[33:0])
						: cs_q + $signed(div_rsp.quot[33:0]);
				end
			end
			ST_SC: begin
				unique case (quad_q)
					2'd0: begin s_q <= ss_q;  c_q <= cs_q;  end
					2'd1: begin s_q <= cs_q;  c_q <= -ss_q; end
					2'd2: begin s_q <= -ss_q; c_q <= -cs_q; end
					2'd3: begin s_q <= -cs_q; c_q <= ss_q;  end
					default: begin s_q <= ss_q; c_q <= cs_q; end
				endcase
			end
			ST_NORM: begin
				sum_q <= '0;
				if (m_q[32] || m_q[31]) begin
					for (int k = 0; k < 3; k++) md_q[k] <= md_q[k] >> 1;
					m_q <= m_q >> 1;
				end else if (m_q[32:30] == '0) begin
					for (int k = 0; k < 3; k++) md_q[k] <= md_q[k] << 1;
					m_q <= m_q << 1;
				end
			end
			ST_SQ: begin
				if (idx_q != '0) sum_q <= sum_q + 64'(p_q);
				if (idx_q == ROW_LAST) begin
					sqn_q <= sum_q + 64'(p_q);
					res_q <= '0;
					sqb_q <= 64'd1 << 62;
				end
			end
			ST_SQRT: begin
				sqn_q <= sq_n;
				res_q <= sq_r;
				sqb_q <= sqb_q >> 2;
			end
			ST_UDW: begin
				if (div_rsp.done)
					u_q[i_q] <= neg_q[i_q] ? word_t'(-div_rsp.quot[31:0])
						: word_t'(div_rsp.quot[31:0]);
			end
			ST_M1: uu_q <= 32'(mulres);
			ST_M2: acc_q <= 40'(mulres) + ((i_q == j_q) ? 40'(c_q) : 40'sd0);
			ST_M3: rv_q <= acc_q + 40'(mulres);
			ST_M5: ent_q[i_q][j_q] <= sat32(mulres);
			default: begin
			end
		endcase

		if (out_load) begin
			row_index_q <= row_q;
			err_out_q   <= err_q;
			last_row_q  <= (row_q == ROW_LAST);
			if (row_q == ROW_LAST) begin
				c0_q <= '0;
				c1_q <= '0;
				c2_q <= '0;
				c3_q <= ONE_W;
			end else begin
				c0_q <= ent_q[row_q][0];
				c1_q <= ent_q[row_q][1];
				c2_q <= ent_q[row_q][2];
				c3_q <= neg_sat(trans[row_q]);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_index_q;
	assign entry_c0   = c0_q;
	assign entry_c1   = c1_q;
	assign entry_c2   = c2_q;
	assign entry_c3   = c3_q;
	assign axis_error = err_out_q;
	assign last_row   = last_row_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_item_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (row_q == ROW_LAST)) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return after last row");

	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UDS) |-> (res_q >= (64'd1 << Q30)))
		else $error("axis length below normalized range");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_row_q == (row_index_q == ROW_LAST)))
		else $error("last_row out of step with row_index");

endmodule

FILE: rtl/axis_angle_model_matrix_top.sv
// ----------------------------------------------------------------------------
// axis_angle_model_matrix_top
// Builds a 4x4 model matrix (Rodrigues rotation * scale; col 3 = -translation)
// from an angle in degrees and two axis points, one row per output item.
// ----------------------------------------------------------------------------
// Each accepted item yields four row items, rows 0 to 3. A two-entry queue
// lets new items in while the sequencer works. The sequencer handles one item
// at a time; its work for a normal axis is set mostly by sixteen sine and
// cosine series divisions on the shared two-bits-per-cycle divider, plus the
// axis normalization shift, the 32-step square root, three unit-vector
// divisions and the matrix products on the one multiplier. A zero-length axis
// skips all of this. Rows leave through an output register, one per cycle
// when not stalled. Configuration registers are always ready; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module axis_angle_model_matrix_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  aamm_pkg::word_t                       angle_deg,
	input  aamm_pkg::word_t                       axis_start_x,
	input  aamm_pkg::word_t                       axis_start_y,
	input  aamm_pkg::word_t                       axis_start_z,
	input  aamm_pkg::word_t                       axis_end_x,
	input  aamm_pkg::word_t                       axis_end_y,
	input  aamm_pkg::word_t                       axis_end_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            row_index,
	output aamm_pkg::word_t                       entry_c0,
	output aamm_pkg::word_t                       entry_c1,
	output aamm_pkg::word_t                       entry_c2,
	output aamm_pkg::word_t                       entry_c3,
	output logic                                  axis_error,
	output logic                                  last_row,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [aamm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  aamm_pkg::word_t                       cfg_data
);
	import aamm_pkg::*;

	localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;

	word_t [2:0] trans_q;
	word_t [2:0] scale_q;
	item_t       f_item, q_item;
	logic        push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= '0;
			for (int k = 0; k < 3; k++) scale_q[k] <= ONE64[31:0];
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRANS_X: trans_q[0] <= cfg_data;
				REG_TRANS_Y: trans_q[1] <= cfg_data;
				REG_TRANS_Z: trans_q[2] <= cfg_data;
				REG_SCALE_X: scale_q[0] <= cfg_data;
				REG_SCALE_Y: scale_q[1] <= cfg_data;
				REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	aamm_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.angle_deg    (angle_deg),
		.axis_start_x (axis_start_x),
		.axis_start_y (axis_start_y),
		.axis_start_z (axis_start_z),
		.axis_end_x   (axis_end_x),
		.axis_end_y   (axis_end_y),
		.axis_end_z   (axis_end_z),
		.q_full       (q_full),
		.push         (push),
		.item         (f_item)
	);

	aamm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (f_item),
		.pop      (pop),
		.item_out (q_item),
		.full     (q_full),
		.empty    (q_empty)
	);

	aamm_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.pop        (pop),
		.trans      (trans_q),
		.scale      (scale_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.entry_c0   (entry_c0),
		.entry_c1   (entry_c1),
		.entry_c2   (entry_c2),
		.entry_c3   (entry_c3),
		.axis_error (axis_error),
		.last_row   (last_row)
	);

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for axis_angle_model_matrix_top. It drives angle and
// axis items, predicts the four rows of each model matrix in fixed point and
// compares every row item field by field. It runs several register settings,
// extremes among them, with random input gaps and output stall bursts.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import aamm_pkg::*;

	localparam int  LIMIT_CYCLES = 1000000;
	localparam int  FB           = 16;
	localparam longint unsigned DEG_RAD_Q32 = (64'd31415926 << 32) / 64'd1800000000;
	localparam longint ONE30     = longint'(1) << 30;

	typedef struct {
		word_t angle;
		word_t p0[3];
		word_t p1[3];
	} axis_item_t;

	typedef struct {
		logic [1:0] row;
		word_t      col[4];
		logic       err;
		logic       last;
	} matrix_row_t;

	class matrix_scoreboard;
		word_t         regs[6];
		matrix_row_t   rows_due[$];
		int            errors;

		function void reset_regs();
			regs[REG_TRANS_X] = 0;
			regs[REG_TRANS_Y] = 0;
			regs[REG_TRANS_Z] = 0;
			regs[REG_SCALE_X] = 32'sd1 <<< FB;
			regs[REG_SCALE_Y] = 32'sd1 <<< FB;
			regs[REG_SCALE_Z] = 32'sd1 <<< FB;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
			if (idx <= REG_SCALE_Z)
				regs[idx] = val;
		endfunction

		function longint mul_trunc(longint a, longint b);
			longint unsigned ma, mb, p;
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			p = (ma * mb) >> 30;
			return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
		endfunction

		function word_t clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return word_t'(v);
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_item(axis_item_t it);
			longint full, quarter, a, q, rem, s0, c0, s, c, d;
			longint unsigned x, x2, ts, tc, n, m, sum, len;
			longint unsigned md[3];
			longint u[3];
			longint rot[3][3];
			longint kx[3][3];
			bit neg[3];
			bit err;
			matrix_row_t r;
			full = longint'(360) << FB;
			quarter = longint'(90) << FB;
			a = longint'(it.angle) % full;
			if (a < 0)
				a += full;
			q = a / quarter;
			rem = a - q * quarter;
			x = (longint'(rem) * DEG_RAD_Q32) >> (FB + 2);
			x2 = (x * x) >> 30;
			ts = x;
			tc = ONE30;
			s0 = longint'(x);
			c0 = ONE30;
			for (n = 1; n <= 8; n++) begin
				ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
				tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
				if (n[0]) begin
					s0 -= longint'(ts);
					c0 -= longint'(tc);
				end else begin
					s0 += longint'(ts);
					c0 += longint'(tc);
				end
			end
			case (q & 3)
				0: begin s = s0;  c = c0;  end
				1: begin s = c0;  c = -s0; end
				2: begin s = -s0; c = -c0; end
				default: begin s = -c0; c = s0; end
			endcase
			m = 0;
			for (int i = 0; i < 3; i++) begin
				d = longint'(it.p1[i]) - longint'(it.p0[i]);
				neg[i] = d < 0;
				md[i] = d < 0 ? -d : d;
				if (md[i] > m)
					m = md[i];
			end
			err = (m == 0);
			if (!err) begin
				while (m >= (64'd1 << 31)) begin
					for (int i = 0; i < 3; i++)
						md[i] >>= 1;
					m >>= 1;
				end
				while (m < (64'd1 << 30)) begin
					for (int i = 0; i < 3; i++)
						md[i] <<= 1;
					m <<= 1;
				end
				sum = md[0] * md[0] + md[1] * md[1] + md[2] * md[2];
				len = root_floor(sum);
				for (int i = 0; i < 3; i++) begin
					u[i] = longint'((md[i] << 30) / len);
					if (neg[i])
						u[i] = -u[i];
				end
				kx[0][0] = 0;     kx[0][1] = -u[2]; kx[0][2] = u[1];
				kx[1][0] = u[2];  kx[1][1] = 0;     kx[1][2] = -u[0];
				kx[2][0] = -u[1]; kx[2][1] = u[0];  kx[2][2] = 0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						rot[i][j] = mul_trunc(ONE30 - c, mul_trunc(u[i], u[j]))
							+ mul_trunc(s, kx[i][j]);
						if (i == j)
							rot[i][j] += c;
					end
			end else begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						rot[i][j] = (i == j) ? ONE30 : 0;
			end
			for (int i = 0; i < 4; i++) begin
				r.row = i;
				if (i < 3) begin
					for (int j = 0; j < 3; j++)
						r.col[j] = clamp32(mul_trunc(rot[i][j], longint'(regs[REG_SCALE_X + j])));
					r.col[3] = clamp32(-longint'(regs[i]));
				end else begin
					r.col[0] = 0;
					r.col[1] = 0;
					r.col[2] = 0;
					r.col[3] = 32'sd1 <<< FB;
				end
				r.err = err;
				r.last = (i == 3);
				rows_due.push_back(r);
			end
		endfunction

		function void check_row(matrix_row_t got);
			matrix_row_t e;
			if (rows_due.size() == 0) begin
				$error("row item with nothing expected: row %0d", got.row);
				errors++;
				return;
			end
			e = rows_due.pop_front();
			if (got.row !== e.row) begin
				$error("row_index: expected %0d, got %0d", e.row, got.row);
				errors++;
			end
			for (int j = 0; j < 4; j++)
				if (got.col[j] !== e.col[j]) begin
					$error("entry_c%0d: expected %h, got %h", j, e.col[j], got.col[j]);
					errors++;
				end
			if (got.err !== e.err) begin
				$error("axis_error: expected %b, got %b", e.err, got.err);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last_row: expected %b, got %b", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	word_t                angle_deg = '0;
	word_t                axis_start_x = '0, axis_start_y = '0, axis_start_z = '0;
	word_t                axis_end_x = '0, axis_end_y = '0, axis_end_z = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           row_index;
	word_t                entry_c0, entry_c1, entry_c2, entry_c3;
	logic                 axis_error, last_row;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t                cfg_data = '0;

	matrix_scoreboard     sb = new;
	bit                   quiet = 1'b0;
	int                   cycles = 0;
	int                   out_hold = 0;

	axis_angle_model_matrix_top #(.FRAC_BITS(FB)) DUT (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_hold > 0)
			out_hold--;
		else if (!quiet && $urandom_range(0, 7) == 0)
			out_hold = $urandom_range(1, 14);
		out_stall <= (out_hold > 0);
	end

	always @(posedge clk) begin
		matrix_row_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.row = row_index;
			got.col[0] = entry_c0;
			got.col[1] = entry_c1;
			got.col[2] = entry_c2;
			got.col[3] = entry_c3;
			got.err = axis_error;
			got.last = last_row;
			sb.check_row(got);
		end
	end

	function automatic axis_item_t make_item(word_t ang, word_t sx, word_t sy, word_t sz,
		word_t ex, word_t ey, word_t ez);
		axis_item_t it;
		it.angle = ang;
		it.p0[0] = sx; it.p0[1] = sy; it.p0[2] = sz;
		it.p1[0] = ex; it.p1[1] = ey; it.p1[2] = ez;
		return it;
	endfunction

	function automatic axis_item_t random_item();
		axis_item_t it;
		int shift;
		if ($urandom_range(0, 1))
			it.angle = $urandom;
		else
			it.angle = $urandom_range(0, 1440 << FB) - (720 << FB);
		shift = $urandom_range(0, 31);
		for (int i = 0; i < 3; i++) begin
			it.p0[i] = $urandom;
			case ($urandom_range(0, 9))
				0: it.p1[i] = $urandom;
				1: it.p1[i] = it.p0[i];
				default: it.p1[i] = it.p0[i] + (word_t'($urandom) >>> shift);
			endcase
		end
		if ($urandom_range(0, 11) == 0)
			it.p1 = it.p0;
		return it;
	endfunction

	task automatic send_item(axis_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		angle_deg <= it.angle;
		axis_start_x <= it.p0[0];
		axis_start_y <= it.p0[1];
		axis_start_z <= it.p0[2];
		axis_end_x <= it.p1[0];
		axis_end_y <= it.p1[1];
		axis_end_z <= it.p1[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.rows_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic write_all(word_t tx, word_t ty, word_t tz, word_t kx, word_t ky, word_t kz);
		write_reg(REG_TRANS_X, tx);
		write_reg(REG_TRANS_Y, ty);
		write_reg(REG_TRANS_Z, tz);
		write_reg(REG_SCALE_X, kx);
		write_reg(REG_SCALE_Y, ky);
		write_reg(REG_SCALE_Z, kz);
	endtask

	task automatic random_items(int count, bit hold_once);
		for (int k = 0; k < count; k++) begin
			send_item(random_item());
			if (hold_once && k == count / 2)
				drain();
		end
	endtask

	initial begin
		word_t one;
		one = 32'sd1 <<< FB;
		sb.reset_regs();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// special angles, zero-length and extreme axes
		send_item(make_item(0, 0, 0, 0, 0, 0, one));
		send_item(make_item(90 << FB, 0, 0, 0, 0, 0, one));
		send_item(make_item(180 << FB, 0, 0, 0, 0, 0, one));
		send_item(make_item(270 << FB, 0, 0, 0, one, 0, 0));
		send_item(make_item(360 << FB, 0, 0, 0, 0, one, 0));
		send_item(make_item(-(90 << FB), 0, 0, 0, one, one, one));
		send_item(make_item(-(360 << FB), 1, 2, 3, 4, 5, 6));
		send_item(make_item(45 << FB, 0, 0, 0, one, one, one));
		send_item(make_item((90 << FB) - 1, 0, 0, 0, -1, -2, 3));
		send_item(make_item(1, 0, 0, 0, 0, 1, 0));
		send_item(make_item(32'sh7fffffff, 0, 0, 0, one, 0, 0));
		send_item(make_item(32'sh80000000, 0, 0, 0, 0, -one, 0));
		send_item(make_item(30 << FB, 5, 5, 5, 5, 5, 5));
		send_item(make_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_item(make_item(60 << FB, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_item(make_item(120 << FB, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_item(make_item(200 << FB, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 1));
		send_item(make_item(-1, 0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0));
		drain();

		// saturating translation and extreme scales; out-of-range index ignored
		write_all(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 0);
		write_reg(3'd6, 32'h1234_5678);
		write_reg(3'd7, 32'hffff_ffff);
		send_item(make_item(0, 0, 0, 0, 0, 0, one));
		send_item(make_item(33 << FB, 0, 0, 0, one, -one, one));
		send_item(make_item(10 << FB, 9, 9, 9, 9, 9, 9));
		random_items(30, 1'b0);
		drain();

		write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_items(40, 1'b1);
		drain();

		write_all($urandom, $urandom, $urandom, -one, one <<< 3, one >>> 4);
		random_items(40, 1'b0);
		drain();

		quiet = 1'b1;
		write_all(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 1, 32'sh80000000);
		random_items(40, 1'b0);
		drain();
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

FILE: axis_angle_model_matrix_top.f
rtl/aamm_pkg.sv
rtl/aamm_front.sv
rtl/aamm_queue.sv
rtl/aamm_div.sv
rtl/aamm_back.sv
rtl/axis_angle_model_matrix_top.sv
sim/testbench.sv
